### hdl/plro_pkg.sv
package plro_pkg;

    localparam int COORD_W   = 32;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int NUM_EDGES = 4;
    localparam int NUM_SUB   = 4;
    localparam int NUM_STEPS = NUM_EDGES * NUM_SUB;
    localparam int STEP_W    = $clog2(NUM_STEPS);
    localparam int CFG_IDX_W = 2;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_LEFT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOP    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic              load;
        logic              issue;
        logic [STEP_W-1:0] step;
        logic              commit;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic have_prev;
        logic pipe_busy;
        logic out_full;
        logic last;
    } t_dp_stat;

endpackage

### hdl/polyline_rect_overlap_unit.sv
// Channel    Dir  Handshake                       Payload
// s_axis     in   i_s_axis_tvalid/o_s_axis_tready tdata {vertex_y, vertex_x}, tlast final_vertex
// m_axis     out  o_m_axis_tvalid/i_m_axis_tready tdata {7'b0, overlaps}, one beat per polyline
// cfg        in   i_cfg_we (write, no wait)       i_cfg_idx, i_cfg_data
//
// A vertex with a predecessor goes from accept to next accept through accept,
// 16 cross-product signs (4 per rectangle edge) through one shared pair of 33x33 multipliers,
// one sign per cycle, pipeline drain and commit.
// The first vertex of a polyline goes from accept straight to commit.
// Reset (i_rst_n low, synchronous) clears the rectangle to zero and drops any held vertex.
// A final vertex waits in commit while the result beat is still held by the sink.
module polyline_rect_overlap_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // vertex beats
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // [31:0] vertex_x, [63:32] vertex_y
    input  logic        i_s_axis_tlast,   // final_vertex
    // result beats
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [0] overlaps, [7:1] zero
    // config writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    import plro_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_overlaps;

    // sequencer: accept, sign-test steps, drain, commit
    plro_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd)
    );

    // rectangle regs, vertex regs, multiplier pipe, sticky hit, result register
    plro_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_x        (i_s_axis_tdata[31:0]),
        .i_y        (i_s_axis_tdata[63:32]),
        .i_last     (i_s_axis_tlast),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_m_ready  (i_m_axis_tready),
        .o_m_valid  (o_m_axis_tvalid),
        .o_overlaps (w_overlaps)
    );

    assign o_m_axis_tdata = {7'b0, w_overlaps};

endmodule

### hdl/plro_ctrl.sv
module plro_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_valid,
    output logic               o_s_ready,
    input  plro_pkg::t_dp_stat i_stat,
    output plro_pkg::t_dp_cmd  o_cmd
);
    import plro_pkg::*;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step,  n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_step    = r_step;
        o_cmd     = '0;
        o_s_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    // first vertex of a run has no segment to test
                    n_state    = i_stat.have_prev ? ST_RUN : ST_DONE;
                end
            end
            ST_RUN: begin
                o_cmd.issue = 1'b1;
                o_cmd.step  = r_step;
                n_step      = r_step + 1'b1;
                if (r_step == STEP_W'(NUM_STEPS - 1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold a final vertex until the result register is free
                if (!(i_stat.last && i_stat.out_full)) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### hdl/plro_dp.sv
module plro_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [plro_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [plro_pkg::COORD_W-1:0]        i_cfg_data,
    input  logic signed [plro_pkg::COORD_W-1:0] i_x,
    input  logic signed [plro_pkg::COORD_W-1:0] i_y,
    input  logic                                i_last,
    input  plro_pkg::t_dp_cmd                   i_cmd,
    output plro_pkg::t_dp_stat                  o_stat,
    input  logic                                i_m_ready,
    output logic                                o_m_valid,
    output logic                                o_overlaps
);
    import plro_pkg::*;

    function automatic logic signed [DIFF_W-1:0] dif(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        return {a[COORD_W-1], a} - {b[COORD_W-1], b};
    endfunction

    function automatic logic inside_span(
        input logic signed [COORD_W-1:0] v,
        input logic signed [COORD_W-1:0] e0,
        input logic signed [COORD_W-1:0] e1
    );
        return !((v < e0 && v < e1) || (v > e0 && v > e1));
    endfunction

    // rectangle
    logic signed [COORD_W-1:0] r_left, r_right, r_top, r_bottom;
    // segment endpoints p (previous) and q (current)
    logic signed [COORD_W-1:0] r_px, r_py, r_qx, r_qy;
    logic                      r_last, r_have_prev, r_hit;

    // multiplier pipeline
    logic                      r_v1, r_v2;
    logic [STEP_W-1:0]         r_k1, r_k2;
    logic signed [DIFF_W-1:0]  r_op_a, r_op_b, r_op_c, r_op_d;
    logic signed [PROD_W-1:0]  r_prod_ab, r_prod_cd;
    logic [NUM_STEPS-1:0]      r_pos, r_neg;

    logic                      r_out_valid, r_out_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_right  <= '0;
            r_top    <= '0;
            r_bottom <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LEFT:   r_left   <= i_cfg_data;
                REG_RIGHT:  r_right  <= i_cfg_data;
                REG_TOP:    r_top    <= i_cfg_data;
                REG_BOTTOM: r_bottom <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // operand select for one cross-product sign
    logic signed [COORD_W-1:0] c_rx, c_ry, c_sx, c_sy;
    logic signed [DIFF_W-1:0]  c_a, c_b, c_c, c_d;

    always_comb begin
        case (i_cmd.step[STEP_W-1:2])
            2'd0: begin    // top edge, left to right
                c_rx = r_left;  c_ry = r_top;    c_sx = r_right; c_sy = r_top;
            end
            2'd1: begin    // right edge
                c_rx = r_right; c_ry = r_top;    c_sx = r_right; c_sy = r_bottom;
            end
            2'd2: begin    // bottom edge
                c_rx = r_right; c_ry = r_bottom; c_sx = r_left;  c_sy = r_bottom;
            end
            default: begin // left edge
                c_rx = r_left;  c_ry = r_bottom; c_sx = r_left;  c_sy = r_top;
            end
        endcase
        // sign of c_a*c_b - c_c*c_d
        case (i_cmd.step[1:0])
            2'd0: begin    // r against p->q
                c_a = dif(r_qx, r_px); c_b = dif(c_ry, r_py);
                c_c = dif(c_rx, r_px); c_d = dif(r_qy, r_py);
            end
            2'd1: begin    // s against p->q
                c_a = dif(r_qx, r_px); c_b = dif(c_sy, r_py);
                c_c = dif(c_sx, r_px); c_d = dif(r_qy, r_py);
            end
            2'd2: begin    // p against r->s
                c_a = dif(c_sx, c_rx); c_b = dif(r_py, c_ry);
                c_c = dif(r_px, c_rx); c_d = dif(c_sy, c_ry);
            end
            default: begin // q against r->s
                c_a = dif(c_sx, c_rx); c_b = dif(r_qy, c_ry);
                c_c = dif(r_qx, c_rx); c_d = dif(c_sy, c_ry);
            end
        endcase
    end

    logic signed [PROD_W:0] c_diff;
    assign c_diff = {r_prod_ab[PROD_W-1], r_prod_ab} - {r_prod_cd[PROD_W-1], r_prod_cd};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
        end
        r_k1      <= i_cmd.step;
        r_k2      <= r_k1;
        r_op_a    <= c_a;
        r_op_b    <= c_b;
        r_op_c    <= c_c;
        r_op_d    <= c_d;
        r_prod_ab <= r_op_a * r_op_b;
        r_prod_cd <= r_op_c * r_op_d;
        if (r_v2) begin
            r_pos[r_k2] <= !c_diff[PROD_W] && (c_diff != '0);
            r_neg[r_k2] <= c_diff[PROD_W];
        end
    end

    // strict crossing per edge: both sign pairs of opposite sign
    logic c_cross;
    always_comb begin
        c_cross = 1'b0;
        for (int e = 0; e < NUM_EDGES; e++) begin
            c_cross = c_cross
                | (((r_pos[4*e]   & r_neg[4*e+1]) | (r_neg[4*e]   & r_pos[4*e+1]))
                &  ((r_pos[4*e+2] & r_neg[4*e+3]) | (r_neg[4*e+2] & r_pos[4*e+3])));
        end
    end

    logic c_in_p, c_in_q, c_seg_hit;
    assign c_in_p = inside_span(r_px, r_left, r_right) && inside_span(r_py, r_top, r_bottom);
    assign c_in_q = inside_span(r_qx, r_left, r_right) && inside_span(r_qy, r_top, r_bottom);
    assign c_seg_hit = r_have_prev && (c_in_p || c_in_q || c_cross);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px        <= '0;
            r_py        <= '0;
            r_have_prev <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                if (r_last) begin
                    r_px        <= '0;
                    r_py        <= '0;
                    r_have_prev <= 1'b0;
                    r_hit       <= 1'b0;
                end else begin
                    r_px        <= r_qx;
                    r_py        <= r_qy;
                    r_have_prev <= 1'b1;
                    r_hit       <= r_hit | c_seg_hit;
                end
            end
            if (i_cmd.commit && r_last) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (i_cmd.load) begin
            r_qx   <= i_x;
            r_qy   <= i_y;
            r_last <= i_last;
        end
        if (i_cmd.commit && r_last) begin
            r_out_bit <= r_hit | c_seg_hit;
        end
    end

    assign o_stat.have_prev = r_have_prev;
    assign o_stat.pipe_busy = r_v1 | r_v2;
    assign o_stat.out_full  = r_out_valid & ~i_m_ready;
    assign o_stat.last      = r_last;

    assign o_m_valid  = r_out_valid;
    assign o_overlaps = r_out_bit;

endmodule
